### rtl/jnas_pkg.sv
// Shared definitions for the Jacobi eight-neighbor average sweep.
// Widths, reset values, register indexes, item flags and the dimension clamp.
// No dependencies.
package jnas_pkg;

    localparam int DATA_W         = 32;
    localparam int DIM_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [DIM_W-1:0]  GRID_WIDTH_RST  = DIM_W'(1024);
    localparam logic [DIM_W-1:0]  GRID_HEIGHT_RST = DIM_W'(1024);
    localparam logic [DATA_W-1:0] THRESH_RST      = DATA_W'(65536);   // 1.0 in Q16.16

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CONV_THRESH = CFG_IDX_W'(2);

    // per-item control bits that travel down the pipeline
    typedef struct packed {
        logic emit;         // interior cell, a result follows
        logic frame_last;   // last sample of the frame
    } jnas_flags_t;

    // Last index along one dimension: size clamped to [3, maxv], minus one.
    function automatic logic [31:0] dim_last(logic [DIM_W-1:0] dim, int maxv);
        logic [31:0] d;
        logic [31:0] res;
        d = 32'(dim);
        if (d < 32'd3)
        begin
            res = 32'd2;
        end
        else if (d > 32'(maxv))
        begin
            res = 32'(maxv) - 32'd1;
        end
        else
        begin
            res = d - 32'd1;
        end
        return res;
    endfunction

endpackage

### rtl/jnas_line_buf.sv
// Two line stores: row r-1 (a) and row r-2 (b), one column address per sample.
// Read data registered; b is refilled from a's read data as the item leaves stage 1.
// Depends on jnas_pkg.
module jnas_line_buf
    import jnas_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [AW-1:0]            addr,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     wb_en,
    output logic signed [DATA_W-1:0] top,
    output logic signed [DATA_W-1:0] mid
);

    logic signed [DATA_W-1:0] mem_a [MAX_WIDTH];
    logic signed [DATA_W-1:0] mem_b [MAX_WIDTH];
    logic signed [DATA_W-1:0] top_reg;
    logic signed [DATA_W-1:0] mid_reg;
    logic [AW-1:0]            addr_reg;

    // row r-1 store: read old, write new sample at the same column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mid_reg       <= mem_a[addr];
            mem_a[addr]   <= sample;
            addr_reg      <= addr;
        end
    end

    // row r-2 store: takes the old row r-1 value once the item moves on
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            top_reg <= mem_b[addr];
        end
        if (wb_en)
        begin
            mem_b[addr_reg] <= mid_reg;
        end
    end

    assign top = top_reg;
    assign mid = mid_reg;

endmodule

### rtl/jnas_window.sv
// 3x3 window: stage 1 holds the sample with its line store reads and shifts the
// window; stage 2 holds four pairwise sums of the eight neighbors and the center.
// Depends on jnas_pkg.
module jnas_window
    import jnas_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic signed [DATA_W-1:0]   sample,
    input  jnas_flags_t                flags_in,
    input  logic signed [DATA_W-1:0]   top,
    input  logic signed [DATA_W-1:0]   mid,
    output logic                       ready,
    output logic                       fire,
    output logic                       s2_valid,
    input  logic                       s2_ready,
    output logic signed [DATA_W:0]     pair0,
    output logic signed [DATA_W:0]     pair1,
    output logic signed [DATA_W:0]     pair2,
    output logic signed [DATA_W:0]     pair3,
    output logic signed [DATA_W-1:0]   center,
    output jnas_flags_t                s2_flags
);

    logic                     v1_reg, v1_next;
    logic signed [DATA_W-1:0] s1_reg;
    jnas_flags_t              flags1_reg;
    logic signed [DATA_W-1:0] win_reg [6];

    logic                     v2_reg, v2_next;
    logic signed [DATA_W:0]   pair_reg [4];
    logic signed [DATA_W-1:0] center_reg;
    jnas_flags_t              flags2_reg;

    logic load2;
    logic fire2;

    // non-interior items retire from stage 1 without needing stage 2
    assign fire2   = v2_reg && s2_ready;
    assign fire    = v1_reg && (!flags1_reg.emit || !v2_reg || s2_ready);
    assign ready   = !v1_reg || fire;
    assign load2   = fire && flags1_reg.emit;
    assign v1_next = load || (v1_reg && !fire);
    assign v2_next = load2 || (v2_reg && !fire2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            if (fire)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= top;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= mid;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= s1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg     <= sample;
            flags1_reg <= flags_in;
        end
        if (load2)
        begin
            pair_reg[0] <= (DATA_W+1)'(win_reg[0]) + (DATA_W+1)'(win_reg[1]);
            pair_reg[1] <= (DATA_W+1)'(top)        + (DATA_W+1)'(win_reg[2]);
            pair_reg[2] <= (DATA_W+1)'(mid)        + (DATA_W+1)'(win_reg[4]);
            pair_reg[3] <= (DATA_W+1)'(win_reg[5]) + (DATA_W+1)'(s1_reg);
            center_reg  <= win_reg[3];
            flags2_reg  <= flags1_reg;
        end
    end

    assign s2_valid = v2_reg;
    assign pair0    = pair_reg[0];
    assign pair1    = pair_reg[1];
    assign pair2    = pair_reg[2];
    assign pair3    = pair_reg[3];
    assign center   = center_reg;
    assign s2_flags = flags2_reg;

endmodule

### rtl/jnas_reduce.sv
// Stage 3: eight-neighbor sum and floor divide by 8 (arithmetic shift).
// Stage 4: absolute change from the old center value.
// Depends on jnas_pkg.
module jnas_reduce
    import jnas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W:0]   pair0,
    input  logic signed [DATA_W:0]   pair1,
    input  logic signed [DATA_W:0]   pair2,
    input  logic signed [DATA_W:0]   pair3,
    input  logic signed [DATA_W-1:0] center,
    input  jnas_flags_t              flags_in,
    output logic                     s4_valid,
    input  logic                     s4_ready,
    output logic signed [DATA_W-1:0] mean,
    output logic [DATA_W-1:0]        change,
    output jnas_flags_t              s4_flags
);

    logic                     v3_reg, v3_next;
    logic signed [DATA_W-1:0] mean3_reg;
    logic signed [DATA_W-1:0] center3_reg;
    jnas_flags_t              flags3_reg;

    logic                     v4_reg, v4_next;
    logic signed [DATA_W-1:0] mean4_reg;
    logic [DATA_W-1:0]        change4_reg;
    jnas_flags_t              flags4_reg;

    logic                     load3, fire3, fire4;
    logic signed [DATA_W+2:0] sum;
    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W:0]   diff_abs;

    assign fire4    = v4_reg && s4_ready;
    assign fire3    = v3_reg && (!v4_reg || s4_ready);
    assign in_ready = !v3_reg || fire3;
    assign load3    = in_valid && in_ready;
    assign v3_next  = load3 || (v3_reg && !fire3);
    assign v4_next  = fire3 || (v4_reg && !fire4);

    assign sum = (DATA_W+3)'(pair0) + (DATA_W+3)'(pair1)
               + (DATA_W+3)'(pair2) + (DATA_W+3)'(pair3);

    assign diff     = (DATA_W+1)'(mean3_reg) - (DATA_W+1)'(center3_reg);
    assign diff_abs = diff[DATA_W] ? -diff : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            mean3_reg   <= sum[DATA_W+2:3];   // floor of sum / 8
            center3_reg <= center;
            flags3_reg  <= flags_in;
        end
        if (fire3)
        begin
            mean4_reg   <= mean3_reg;
            change4_reg <= diff_abs[DATA_W-1:0];
            flags4_reg  <= flags3_reg;
        end
    end

    assign s4_valid = v4_reg;
    assign mean     = mean4_reg;
    assign change   = change4_reg;
    assign s4_flags = flags4_reg;

endmodule

### rtl/jacobi_neighbor_average_sweep.sv
// Jacobi eight-neighbor average sweep, streaming top level.
// Depends on jnas_pkg, jnas_line_buf, jnas_window, jnas_reduce.
//
// Usage:
//  - Input channel (in_valid/in_ready, sample): one frame of signed Q16.16
//    samples in raster order, boundary rows and columns included.
//  - Output channel (out_valid/out_ready): one transaction per interior cell,
//    carrying the mean of its eight neighbors, the running largest change of
//    the frame, and on the frame's last interior cell frame_last plus the
//    converged flag (max change at or below converge_threshold).
//  - Config port (cfg_we/cfg_index/cfg_data): grid_width, grid_height and
//    converge_threshold, written only while no transaction is in flight.
//    Sizes below 3 act as 3, above MAX_WIDTH/MAX_HEIGHT act as the maximum.
//  - Throughput: one sample per cycle while out_ready stays high. A result is
//    registered in turn by the line store read at the accepting edge, then
//    the pair sums, sum and shift, change, and the output register.
//  - Reset clears counters, window, running max and all valid bits; the line
//    stores are not cleared and need no clearing pass.
//  - When the receiver stalls, results back up through the pipeline stages
//    and in_ready drops only once every stage is full.
module jacobi_neighbor_average_sweep
    import jnas_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] new_value,
    output logic [DATA_W-1:0]        max_change,
    output logic                     converged,
    output logic                     frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // configuration registers
    logic [DIM_W-1:0]  grid_width_reg;
    logic [DIM_W-1:0]  grid_height_reg;
    logic [DATA_W-1:0] thresh_reg;

    // raster position of the next sample
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] last_col_idx;
    logic [RW-1:0] last_row_idx;
    logic          last_col, last_row;
    logic          accept;
    jnas_flags_t   flags0;

    // line store and window links
    logic signed [DATA_W-1:0] top, mid;
    logic                     s1_fire;
    logic                     s2_valid, s2_ready;
    logic signed [DATA_W:0]   pair0, pair1, pair2, pair3;
    logic signed [DATA_W-1:0] center;
    jnas_flags_t              s2_flags;

    // reduce outputs
    logic                     s4_valid, s4_ready;
    logic signed [DATA_W-1:0] s4_mean;
    logic [DATA_W-1:0]        s4_change;
    jnas_flags_t              s4_flags;

    // output stage and running max
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] new_value_reg;
    logic [DATA_W-1:0]        max_change_reg;
    logic                     converged_reg;
    logic                     frame_last_reg;
    logic [DATA_W-1:0]        frame_max_reg, frame_max_next;
    logic [DATA_W-1:0]        max_upd;
    logic                     out_load;

    //------------------------------------------------------------------
    // Configuration
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            thresh_reg      <= THRESH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DIM_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[DIM_W-1:0];
                REG_CONV_THRESH: thresh_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Raster counters; a counter at or past the last index wraps
    //------------------------------------------------------------------
    assign last_col_idx = AW'(dim_last(grid_width_reg, MAX_WIDTH));
    assign last_row_idx = RW'(dim_last(grid_height_reg, MAX_HEIGHT));
    assign last_col     = col_reg >= last_col_idx;
    assign last_row     = row_reg >= last_row_idx;
    assign accept       = in_valid && in_ready;

    assign flags0.emit       = (row_reg >= RW'(2)) && (col_reg >= AW'(2));
    assign flags0.frame_last = last_col && last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    //------------------------------------------------------------------
    // Datapath
    //------------------------------------------------------------------
    jnas_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_buf (
        .clk    (clk),
        .rd_en  (accept),
        .addr   (col_reg),
        .sample (sample),
        .wb_en  (s1_fire),
        .top    (top),
        .mid    (mid)
    );

    jnas_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .sample   (sample),
        .flags_in (flags0),
        .top      (top),
        .mid      (mid),
        .ready    (in_ready),
        .fire     (s1_fire),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .pair0    (pair0),
        .pair1    (pair1),
        .pair2    (pair2),
        .pair3    (pair3),
        .center   (center),
        .s2_flags (s2_flags)
    );

    jnas_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid),
        .in_ready (s2_ready),
        .pair0    (pair0),
        .pair1    (pair1),
        .pair2    (pair2),
        .pair3    (pair3),
        .center   (center),
        .flags_in (s2_flags),
        .s4_valid (s4_valid),
        .s4_ready (s4_ready),
        .mean     (s4_mean),
        .change   (s4_change),
        .s4_flags (s4_flags)
    );

    //------------------------------------------------------------------
    // Output register with running frame maximum
    //------------------------------------------------------------------
    assign s4_ready       = !out_valid_reg || out_ready;
    assign out_load       = s4_valid && s4_ready;
    assign out_valid_next = out_load || (out_valid_reg && !out_ready);
    assign max_upd        = (s4_change > frame_max_reg) ? s4_change : frame_max_reg;

    // the frame's last result clears the running max for the next frame
    always_comb
    begin
        frame_max_next = frame_max_reg;
        if (out_load)
        begin
            frame_max_next = s4_flags.frame_last ? '0 : max_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            frame_max_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            frame_max_reg <= frame_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            new_value_reg  <= s4_mean;
            max_change_reg <= max_upd;
            converged_reg  <= s4_flags.frame_last && (max_upd <= thresh_reg);
            frame_last_reg <= s4_flags.frame_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_value  = new_value_reg;
    assign max_change = max_change_reg;
    assign converged  = converged_reg;
    assign frame_last = frame_last_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_conv_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && converged |-> frame_last)
        else $error("converged set on a result that does not end the frame");

    a_max_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && s4_flags.frame_last |=> frame_max_reg == '0)
        else $error("running max not cleared after frame end");

    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> max_change >= $past(frame_max_reg))
        else $error("reported max change below running max");

endmodule
